@@ rtl/swrf_pkg.sv @@
// Shared types and constants for the wall repulsion force block.
// Holds the configuration record, the queue entry format and register index codes.
// No dependencies.
package swrf_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    // Square root of a 2*WORD_BITS sum: one result bit per step.
    localparam int ROOT_STEPS = WORD_BITS;
    // Quotient bits of r0/r below the saturation point.
    localparam int FDIV_STEPS = WORD_BITS - 1;
    // Quotient bits of a unit vector component, which never exceeds 1.0.
    localparam int UDIV_STEPS = FRAC_BITS + 1;
    localparam int QUEUE_DEPTH = 4;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_WALL_STYLE      = 3'd0,
        REG_WALL_LOW        = 3'd1,
        REG_WALL_HIGH       = 3'd2,
        REG_CYLINDER_RADIUS = 3'd3,
        REG_CUTOFF_DISTANCE = 3'd4,
        REG_STRENGTH        = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STYLE_X   = 2'd0,
        STYLE_Y   = 2'd1,
        STYLE_Z   = 2'd2,
        STYLE_CYL = 2'd3
    } wall_style_t;

    typedef struct packed {
        wall_style_t        wall_style;
        logic signed [31:0] wall_low;
        logic signed [31:0] wall_high;
        logic [30:0]        cylinder_radius;
        logic [30:0]        cutoff_distance;
        logic signed [31:0] strength;
    } cfg_t;

    // One classified particle passed from the front end to the force unit.
    typedef struct packed {
        logic        apply;
        logic        last;
        logic [2:0]  neg;
        logic [2:0]  nz;
        logic        cyl;
        logic [1:0]  axis;
        logic [30:0] r;
        logic [31:0] rho;
        logic [31:0] axm;
        logic [31:0] aym;
    } work_t;

endpackage

@@ rtl/swrf_queue.sv @@
// Short queue between the classification front end and the force unit.
// Depends on swrf_pkg for the entry format and depth.
module swrf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  swrf_pkg::work_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output swrf_pkg::work_t pop_item
);
    import swrf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    work_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    // Storage is written at the tail on every accepted push.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/swrf_front.sv @@
// Front end: accepts particles, finds the wall offset and classifies them.
// Plane offsets take one stage; the cylinder radius goes through a pipelined square root.
// Depends on swrf_pkg.
module swrf_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  swrf_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic               in_group,
    input  logic               in_last,
    output logic               out_valid,
    input  logic               out_ready,
    output swrf_pkg::work_t    out_item
);
    import swrf_pkg::*;

    localparam int NST = ROOT_STEPS + 3;

    typedef struct packed {
        logic               group;
        logic               last;
        logic signed [32:0] plane_d;
        logic [31:0]        axm;
        logic [31:0]        aym;
        logic               xneg;
        logic               xnz;
        logic               yneg;
        logic               ynz;
        logic [63:0]        sqx;
        logic [63:0]        sqy;
        logic [63:0]        s;
        logic [31:0]        root;
        logic [33:0]        rem;
    } fstage_t;

    fstage_t          st_reg [NST];
    logic [NST-1:0]   v_reg;
    work_t            out_reg;
    logic             out_v_reg;
    logic             adv;

    fstage_t            st0;
    fstage_t            st1;
    fstage_t            st2;
    logic signed [31:0] p;
    logic signed [32:0] del1;
    logic signed [32:0] del2;

    work_t              item;
    fstage_t            fin;
    logic signed [32:0] dr;
    logic signed [32:0] off;
    logic [32:0]        mag;
    logic               cyl;

    // The whole front end moves unless a finished item waits on a full queue.
    assign adv       = !out_v_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_v_reg;
    assign out_item  = out_reg;

    // Stage 0: nearer-plane offset and the absolute coordinates.
    always_comb begin
        case (cfg.wall_style)
            STYLE_Y: p = pos_y;
            STYLE_Z: p = pos_z;
            default: p = pos_x;
        endcase
        del1 = {p[31], p} - {cfg.wall_low[31], cfg.wall_low};
        del2 = {cfg.wall_high[31], cfg.wall_high} - {p[31], p};
        st0         = '0;
        st0.group   = in_group;
        st0.last    = in_last;
        st0.plane_d = (del1 < del2) ? del1 : -del2;
        st0.axm     = pos_x[31] ? 32'(-pos_x) : pos_x;
        st0.aym     = pos_y[31] ? 32'(-pos_y) : pos_y;
        st0.xneg    = pos_x[31];
        st0.xnz     = |pos_x;
        st0.yneg    = pos_y[31];
        st0.ynz     = |pos_y;
    end

    // Stage 1 squares both coordinates, stage 2 sums them.
    always_comb begin
        st1     = st_reg[0];
        st1.sqx = st_reg[0].axm * st_reg[0].axm;
        st1.sqy = st_reg[0].aym * st_reg[0].aym;
        st2      = st_reg[1];
        st2.s    = st_reg[1].sqx + st_reg[1].sqy;
        st2.root = '0;
        st2.rem  = '0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0] <= st0;
            st_reg[1] <= st1;
            st_reg[2] <= st2;
        end
    end

    // Square root, one result bit per stage from the top pair of bits down.
    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        fstage_t     cur;
        fstage_t     nxt;
        logic [35:0] sh;
        logic [35:0] trial;
        always_comb begin
            cur   = st_reg[2+k];
            sh    = {cur.rem, cur.s[63-2*k -: 2]};
            trial = {2'b00, cur.root, 2'b01};
            nxt   = cur;
            if (sh >= trial) begin
                nxt.rem  = 34'(sh - trial);
                nxt.root = {cur.root[30:0], 1'b1};
            end else begin
                nxt.rem  = sh[33:0];
                nxt.root = {cur.root[30:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                st_reg[3+k] <= nxt;
            end
        end
    end

    // Final stage: pick the offset, test the cutoff and set the component signs.
    // A particle on the cylinder axis gets no force at all.
    always_comb begin
        fin  = st_reg[NST-1];
        cyl  = (cfg.wall_style == STYLE_CYL);
        dr   = $signed({1'b0, fin.root}) - $signed({2'b00, cfg.cylinder_radius});
        off  = cyl ? dr : fin.plane_d;
        mag  = off[32] ? 33'(-off) : 33'(off);
        item       = '0;
        item.apply = fin.group && (off != '0) && (mag <= {2'b00, cfg.cutoff_distance})
                     && (!cyl || fin.xnz || fin.ynz);
        item.last  = fin.last;
        item.cyl   = cyl;
        item.axis  = cfg.wall_style;
        item.r     = mag[30:0];
        item.rho   = fin.root;
        item.axm   = fin.axm;
        item.aym   = fin.aym;
        if (cyl) begin
            item.neg[0] = fin.xneg ^ off[32];
            item.nz[0]  = fin.xnz;
            item.neg[1] = fin.yneg ^ off[32];
            item.nz[1]  = fin.ynz;
        end else begin
            item.neg[cfg.wall_style] = off[32];
            item.nz[cfg.wall_style]  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= item;
        end
    end

    // Valid bits follow the items through the stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            v_reg     <= {v_reg[NST-2:0], in_valid};
            out_v_reg <= v_reg[NST-1];
        end
    end

endmodule

@@ rtl/swrf_back.sv @@
// Force unit: divides out r0/r and the unit vector, then scales by the 4-2 law.
// Pipelined restoring dividers feed a chain of registered multipliers.
// Depends on swrf_pkg.
module swrf_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  swrf_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  swrf_pkg::work_t    in_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] force_dx,
    output logic signed [31:0] force_dy,
    output logic signed [31:0] force_dz,
    output logic               applied,
    output logic               last_out
);
    import swrf_pkg::*;

    localparam int NBS = FDIV_STEPS + 1;
    localparam int NV  = NBS + 7;
    localparam logic [16:0] UNIT_ONE = 17'(1) << FRAC_BITS;
    localparam logic [30:0] F_MAX    = '1;
    localparam logic [30:0] F_ONE    = 31'(1) << FRAC_BITS;

    typedef struct packed {
        work_t       w;
        logic        fsat;
        logic [32:0] frem;
        logic [30:0] fq;
        logic [32:0] urx;
        logic [32:0] ury;
        logic [16:0] ux;
        logic [16:0] uy;
    } bstage_t;

    typedef struct packed {
        logic        apply;
        logic        last;
        logic [2:0]  neg;
        logic [2:0]  nz;
        logic [16:0] u0;
        logic [16:0] u1;
        logic [16:0] u2;
    } carry_t;

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    function automatic logic [33:0] div_step(input logic [32:0] rem, input logic [31:0] dvs,
                                             input logic nb);
        logic [33:0] sh;
        logic [33:0] diff;
        logic [33:0] res;
        sh   = {rem, nb};
        diff = sh - {2'b00, dvs};
        if (sh >= {2'b00, dvs}) begin
            res = {1'b1, diff[32:0]};
        end else begin
            res = {1'b0, sh[32:0]};
        end
        return res;
    endfunction

    bstage_t         b_reg [NBS];
    bstage_t         b0;
    logic [NV-1:0]   v_reg;
    logic            adv;
    logic [30:0]     nvec;

    carry_t          ctl_reg [6];
    carry_t          c0;
    logic [30:0]     f;
    logic [61:0]     fprod_reg;
    logic [30:0]     f2_reg;
    logic [61:0]     gprod_reg;
    logic            ge_reg;
    logic [30:0]     g_reg;
    logic [62:0]     mprod_reg;
    logic [63:0]     cprod_reg [3];
    logic [31:0]     dmag;
    logic            dneg;
    logic [31:0]     res [3];
    logic signed [31:0] fx_reg;
    logic signed [31:0] fy_reg;
    logic signed [31:0] fz_reg;
    logic            app_reg;
    logic            last_reg;

    assign adv      = !v_reg[NV-1] || m_ready;
    assign in_ready = adv;
    assign m_valid  = v_reg[NV-1];
    assign force_dx = fx_reg;
    assign force_dy = fy_reg;
    assign force_dz = fz_reg;
    assign applied  = app_reg;
    assign last_out = last_reg;

    // Low dividend bits of r0 << FRAC_BITS that the divider shifts in.
    assign nvec = {cfg.cutoff_distance[FDIV_STEPS-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};

    // Entry stage: saturation test and the upper dividend bits as starting remainders.
    always_comb begin
        b0      = '0;
        b0.w    = in_item;
        b0.fsat = ({15'b0, cfg.cutoff_distance} >= {in_item.r, 15'b0});
        b0.frem = 33'(cfg.cutoff_distance >> (FDIV_STEPS - FRAC_BITS));
        b0.urx  = {2'b00, in_item.axm[31:1]};
        b0.ury  = {2'b00, in_item.aym[31:1]};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_reg[0] <= b0;
        end
    end

    // Divider stages: r0/r over all stages, the unit components over the first ones.
    for (genvar k = 0; k < FDIV_STEPS; k++) begin : g_div
        bstage_t     cur;
        bstage_t     nxt;
        logic [33:0] fs;
        logic [33:0] xs;
        logic [33:0] ys;
        always_comb begin
            cur = b_reg[k];
            nxt = cur;
            fs  = div_step(cur.frem, {1'b0, cur.w.r}, nvec[FDIV_STEPS-1-k]);
            xs  = div_step(cur.urx, cur.w.rho, (k == 0) ? cur.w.axm[0] : 1'b0);
            ys  = div_step(cur.ury, cur.w.rho, (k == 0) ? cur.w.aym[0] : 1'b0);
            nxt.frem = fs[32:0];
            nxt.fq   = {cur.fq[29:0], fs[33]};
            if (k < UDIV_STEPS) begin
                nxt.urx = xs[32:0];
                nxt.ury = ys[32:0];
                nxt.ux  = {cur.ux[15:0], xs[33]};
                nxt.uy  = {cur.uy[15:0], ys[33]};
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                b_reg[k+1] <= nxt;
            end
        end
    end

    // Unit vector: divided components for the cylinder, one axis at 1.0 for planes.
    always_comb begin
        c0       = '0;
        c0.apply = b_reg[NBS-1].w.apply;
        c0.last  = b_reg[NBS-1].w.last;
        c0.neg   = b_reg[NBS-1].w.neg;
        c0.nz    = b_reg[NBS-1].w.nz;
        if (b_reg[NBS-1].w.cyl) begin
            c0.u0 = b_reg[NBS-1].ux;
            c0.u1 = b_reg[NBS-1].uy;
        end else begin
            case (b_reg[NBS-1].w.axis)
                STYLE_X: c0.u0 = UNIT_ONE;
                STYLE_Y: c0.u1 = UNIT_ONE;
                default: c0.u2 = UNIT_ONE;
            endcase
        end
        f    = b_reg[NBS-1].fsat ? F_MAX : b_reg[NBS-1].fq;
        dmag = cfg.strength[31] ? 32'(-cfg.strength) : 32'(cfg.strength);
        dneg = cfg.strength[31];
    end

    // Output saturation with the combined sign of offset and strength.
    always_comb begin
        logic [2:0]  nz;
        logic [2:0]  ng;
        logic [47:0] c;
        nz = ctl_reg[5].nz;
        ng = ctl_reg[5].neg;
        for (int i = 0; i < 3; i++) begin
            c = cprod_reg[i][63:16];
            if (!ctl_reg[5].apply || !nz[i]) begin
                res[i] = '0;
            end else if (ng[i] ^ dneg) begin
                res[i] = (|c[47:31]) ? 32'h8000_0000 : 32'(-{1'b0, c[30:0]});
            end else begin
                res[i] = (|c[47:31]) ? 32'h7fff_ffff : {1'b0, c[30:0]};
            end
        end
    end

    // Multiplier chain: f*f, f2*(f2-1), strength*g, then the three components.
    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg[0] <= c0;
            for (int i = 1; i < 6; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            fprod_reg <= f * f;
            f2_reg    <= (|fprod_reg[61:47]) ? F_MAX : fprod_reg[46:16];
            ge_reg    <= (f2_reg >= F_ONE);
            gprod_reg <= f2_reg * (f2_reg - F_ONE);
            g_reg     <= !ge_reg ? '0 : ((|gprod_reg[61:47]) ? F_MAX : gprod_reg[46:16]);
            mprod_reg <= dmag * g_reg;
            cprod_reg[0] <= mprod_reg[62:16] * ctl_reg[4].u0;
            cprod_reg[1] <= mprod_reg[62:16] * ctl_reg[4].u1;
            cprod_reg[2] <= mprod_reg[62:16] * ctl_reg[4].u2;
            fx_reg   <= res[0];
            fy_reg   <= res[1];
            fz_reg   <= res[2];
            app_reg  <= ctl_reg[5].apply;
            last_reg <= ctl_reg[5].last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NV-2:0], in_valid};
        end
    end

endmodule

@@ rtl/sph_wall_repulsion_force.sv @@
// Top level of the wall repulsion force block: configuration registers and channels.
// Instantiates swrf_front, swrf_queue and swrf_back; depends on swrf_pkg.
//
// Channel   Direction  Content
// s_*       in         particle: tdata {pos_z,pos_y,pos_x}, tuser in_group, tlast
// m_*       out        force: tdata {force_dz,force_dy,force_dx}, tuser applied, tlast
// cfg_*     in         register writes: index, 32-bit data, no read-back
//
// One particle is accepted per cycle unless the front end is stalled. The front end
// holds the 32-stage square root and the force unit the 31-stage divider, with the
// queue between them. Reset is synchronous, active low, and restores the register
// defaults. Front end and force unit stall independently; a stall on the output
// reaches the input only once the four-entry queue has filled.
module sph_wall_repulsion_force (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
    input  logic        s_tuser,   // in_group
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // force_dx [31:0], force_dy [63:32], force_dz [95:64]
    output logic        m_tuser,   // applied
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import swrf_pkg::*;

    cfg_t               cfg_reg;
    logic               q_push_valid;
    logic               q_push_ready;
    work_t              q_push_item;
    logic               q_pop_valid;
    logic               q_pop_ready;
    work_t              q_pop_item;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wall_style      <= STYLE_X;
            cfg_reg.wall_low        <= 32'sh8000_0000;
            cfg_reg.wall_high       <= 32'sh7fff_ffff;
            cfg_reg.cylinder_radius <= '0;
            cfg_reg.cutoff_distance <= '0;
            cfg_reg.strength        <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_WALL_STYLE:      cfg_reg.wall_style      <= wall_style_t'(cfg_wdata[1:0]);
                REG_WALL_LOW:        cfg_reg.wall_low        <= cfg_wdata;
                REG_WALL_HIGH:       cfg_reg.wall_high       <= cfg_wdata;
                REG_CYLINDER_RADIUS: cfg_reg.cylinder_radius <= cfg_wdata[30:0];
                REG_CUTOFF_DISTANCE: cfg_reg.cutoff_distance <= cfg_wdata[30:0];
                REG_STRENGTH:        cfg_reg.strength        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    swrf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pos_x     (s_tdata[31:0]),
        .pos_y     (s_tdata[63:32]),
        .pos_z     (s_tdata[95:64]),
        .in_group  (s_tuser),
        .in_last   (s_tlast),
        .out_valid (q_push_valid),
        .out_ready (q_push_ready),
        .out_item  (q_push_item)
    );

    swrf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item)
    );

    swrf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (q_pop_valid),
        .in_ready (q_pop_ready),
        .in_item  (q_pop_item),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .force_dx (fx),
        .force_dy (fy),
        .force_dz (fz),
        .applied  (m_tuser),
        .last_out (m_tlast)
    );

    assign m_tdata = {fz, fy, fx};

endmodule

@@ dv/tb_sph_wall_repulsion_force.sv @@
// Self-checking testbench for the wall repulsion force block: particles in, force increments out.
// Predicts each result with its own fixed-point model and compares it field by field.
// Depends on swrf_pkg and the RTL of sph_wall_repulsion_force.
module tb_sph_wall_repulsion_force;
    import swrf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint QMAX_RAW = 64'h7fff_ffff;
    localparam longint ONE_Q    = 64'h1_0000;
    localparam int     DRAIN_CYCLES = 200;
    localparam longint CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
        logic               in_group;
        logic               last_particle;
    } particle_t;

    typedef struct packed {
        logic [31:0] force_dz;
        logic [31:0] force_dy;
        logic [31:0] force_dx;
        logic        applied;
        logic        last_out;
    } force_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    // Testbench copy of the registers.
    cfg_t        cfg_shadow;

    particle_t   particle_q[$];
    force_t      expected_forces[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          error_count;
    int          force_count;
    int          applied_count;
    longint      cycle_count;

    sph_wall_repulsion_force i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Integer square root, floor.
    function automatic longint unsigned root_floor(input longint unsigned s);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned clip_mag(input longint unsigned v);
        return (v > QMAX_RAW) ? QMAX_RAW : v;
    endfunction

    function automatic logic [31:0] apply_sign(input longint unsigned mag, input int sgn);
        longint unsigned v;
        if (sgn > 0) return 32'(clip_mag(mag));
        if (sgn < 0) begin
            v = (mag > QMAX_RAW + 1) ? QMAX_RAW + 1 : mag;
            return 32'(-v);
        end
        return 32'd0;
    endfunction

    // Force increment for one particle under the current register settings.
    function automatic force_t wall_force(input particle_t p);
        force_t          res;
        longint          pos[3];
        longint unsigned unit_mag[3];
        int              sg[3];
        longint unsigned r, f, f2, g, m, dmag, axm, aym, s, rho, cut;
        longint          del1, del2, d, dr;
        int              ax, rs, dsign;
        res = '0;
        res.last_out = p.last_particle;
        pos[0] = p.pos_x;
        pos[1] = p.pos_y;
        pos[2] = p.pos_z;
        unit_mag = '{0, 0, 0};
        sg = '{0, 0, 0};
        cut = cfg_shadow.cutoff_distance;
        if (!p.in_group) return res;
        if (cfg_shadow.wall_style != STYLE_CYL) begin
            ax   = int'(cfg_shadow.wall_style);
            del1 = pos[ax] - longint'(cfg_shadow.wall_low);
            del2 = longint'(cfg_shadow.wall_high) - pos[ax];
            d    = (del1 < del2) ? del1 : -del2;
            if (d == 0) return res;
            r = (d > 0) ? d : -d;
            unit_mag[ax] = ONE_Q;
            sg[ax] = (d > 0) ? 1 : -1;
        end else begin
            axm = (pos[0] < 0) ? -pos[0] : pos[0];
            aym = (pos[1] < 0) ? -pos[1] : pos[1];
            s   = axm * axm + aym * aym;
            if (s == 0) return res;
            rho = root_floor(s);
            dr  = longint'(rho) - longint'(cfg_shadow.cylinder_radius);
            if (dr == 0) return res;
            r  = (dr > 0) ? dr : -dr;
            rs = (dr > 0) ? 1 : -1;
            unit_mag[0] = (axm << 16) / rho;
            unit_mag[1] = (aym << 16) / rho;
            sg[0] = (pos[0] > 0) ? rs : ((pos[0] < 0) ? -rs : 0);
            sg[1] = (pos[1] > 0) ? rs : ((pos[1] < 0) ? -rs : 0);
        end
        if (r > cut) return res;
        f     = clip_mag((cut << 16) / r);
        f2    = clip_mag((f * f) >> 16);
        g     = (f2 >= ONE_Q) ? clip_mag((f2 * (f2 - ONE_Q)) >> 16) : 0;
        dmag  = (cfg_shadow.strength < 0) ? -longint'(cfg_shadow.strength)
                                          : longint'(cfg_shadow.strength);
        dsign = (cfg_shadow.strength < 0) ? -1 : 1;
        m     = (dmag * g) >> 16;
        res.force_dx = apply_sign((m * unit_mag[0]) >> 16, sg[0] * dsign);
        res.force_dy = apply_sign((m * unit_mag[1]) >> 16, sg[1] * dsign);
        res.force_dz = apply_sign((m * unit_mag[2]) >> 16, sg[2] * dsign);
        res.applied  = 1'b1;
        return res;
    endfunction

    // Sender: presents the next pending particle; the expectation is logged on acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_forces.push_back(wall_force({s_tdata, s_tuser, s_tlast}));
                void'(particle_q.pop_front());
            end
            if ((!s_tvalid || s_tready) ) begin
                if (((s_tvalid && s_tready) ? particle_q.size() > 0 : particle_q.size() > 0)
                    && ($urandom_range(99) >= send_idle_pct)) begin
                    s_tvalid <= 1'b1;
                    {s_tdata, s_tuser, s_tlast} <= particle_q[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random backpressure and checking of each result transaction.
    always @(posedge aclk) begin
        force_t got;
        force_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                got = {m_tdata, m_tuser, m_tlast};
                force_count++;
                if (expected_forces.size() == 0) begin
                    $display("%0t: unexpected force transaction %h", $time, got);
                    error_count++;
                end else begin
                    want = expected_forces.pop_front();
                    if (got.applied) applied_count++;
                    if (got.force_dx !== want.force_dx || got.force_dy !== want.force_dy ||
                        got.force_dz !== want.force_dz || got.applied !== want.applied ||
                        got.last_out !== want.last_out) begin
                        $display("%0t: force mismatch expected dx=%h dy=%h dz=%h app=%b last=%b",
                                 $time, want.force_dx, want.force_dy, want.force_dz,
                                 want.applied, want.last_out);
                        $display("%0t:                actual   dx=%h dy=%h dz=%h app=%b last=%b",
                                 $time, got.force_dx, got.force_dy, got.force_dz,
                                 got.applied, got.last_out);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // One register write, after which the write port is left idle before the task returns.
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_WALL_STYLE:      cfg_shadow.wall_style      = wall_style_t'(value[1:0]);
            REG_WALL_LOW:        cfg_shadow.wall_low        = value;
            REG_WALL_HIGH:       cfg_shadow.wall_high       = value;
            REG_CYLINDER_RADIUS: cfg_shadow.cylinder_radius = value[30:0];
            REG_CUTOFF_DISTANCE: cfg_shadow.cutoff_distance = value[30:0];
            REG_STRENGTH:        cfg_shadow.strength        = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_walls(input wall_style_t style, input logic [31:0] lo,
                             input logic [31:0] hi, input logic [31:0] radius,
                             input logic [31:0] cutoff, input logic [31:0] d);
        write_reg(REG_WALL_STYLE, 32'(style));
        write_reg(REG_WALL_LOW, lo);
        write_reg(REG_WALL_HIGH, hi);
        write_reg(REG_CYLINDER_RADIUS, radius);
        write_reg(REG_CUTOFF_DISTANCE, cutoff);
        write_reg(REG_STRENGTH, d);
    endtask

    // Waits until every queued particle has been answered, then lets the pipeline settle.
    task automatic drain();
        while (particle_q.size() > 0 || s_tvalid || expected_forces.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic add_particle(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z, input logic grp, input logic lst);
        particle_t p;
        p.pos_x = x;
        p.pos_y = y;
        p.pos_z = z;
        p.in_group = grp;
        p.last_particle = lst;
        particle_q.push_back(p);
    endtask

    // Random coordinate: mostly near the walls, sometimes anywhere.
    function automatic logic [31:0] near_coord(input logic [31:0] center, input int spread);
        if ($urandom_range(9) == 0) return $urandom;
        return center + 32'($signed($urandom_range(2 * spread)) - spread);
    endfunction

    task automatic random_phase(input int count);
        logic [31:0] lo, hi, rad, cut, d, span;
        wall_style_t style;
        logic [31:0] x, y, z;
        style = wall_style_t'($urandom_range(3));
        span  = 32'($urandom_range(32'h40_0000, 32'h10));
        lo    = $urandom_range(3) == 0 ? 32'h8000_0000 : -32'($urandom_range(32'h100_0000));
        hi    = $urandom_range(3) == 0 ? 32'h7fff_ffff : 32'($urandom_range(32'h100_0000));
        rad   = $urandom_range(32'h80_0000);
        cut   = $urandom_range(5) == 0 ? $urandom & 32'h7fff_ffff : span;
        d     = $urandom;
        set_walls(style, lo, hi, rad, cut, d);
        for (int i = 0; i < count; i++) begin
            if (style == STYLE_CYL) begin
                x = near_coord(rad, int'(span));
                y = near_coord(32'd0, int'(span));
                if ($urandom_range(1)) {x, y} = {y, x};
                if ($urandom_range(1)) x = -x;
                z = $urandom;
            end else begin
                x = $urandom;
                y = $urandom;
                z = $urandom;
                case (style)
                    STYLE_X: x = near_coord($urandom_range(1) ? lo : hi, int'(span));
                    STYLE_Y: y = near_coord($urandom_range(1) ? lo : hi, int'(span));
                    default: z = near_coord($urandom_range(1) ? lo : hi, int'(span));
                endcase
            end
            add_particle(x, y, z, $urandom_range(7) != 0, $urandom_range(1));
        end
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_WALL_STYLE;
        cfg_wdata = '0;
        cycle_count = 0;
        error_count = 0;
        force_count = 0;
        applied_count = 0;
        send_idle_pct = 23;
        recv_idle_pct = 80;
        cfg_shadow = '{STYLE_X, 32'h8000_0000, 32'h7fff_ffff, 31'd0, 31'd0, 32'd0};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: no walls, zero cutoff.
        add_particle(32'h0001_0000, 0, 0, 1, 0);
        add_particle(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1, 1);
        drain();

        // X planes at +-4.0, cutoff 1.0, strength 2.0.
        set_walls(STYLE_X, 32'hfffc_0000, 32'h0004_0000, 0, 32'h0001_0000, 32'h0002_0000);
        add_particle(32'h0003_8000, 1, 2, 1, 0);     // near upper plane
        add_particle(32'hfffc_8000, 1, 2, 1, 0);     // near lower plane
        add_particle(32'h0004_0000, 1, 2, 1, 0);     // on the plane
        add_particle(32'h0003_0000, 1, 2, 1, 0);     // exactly at cutoff
        add_particle(32'h0000_0000, 1, 2, 1, 0);     // beyond cutoff
        add_particle(32'h0003_ffff, 1, 2, 1, 0);     // tiny offset, saturating
        add_particle(32'h0003_8000, 1, 2, 0, 1);     // not in the group
        drain();

        // Y and Z planes with negative strength, extreme cutoff.
        set_walls(STYLE_Y, 32'h0000_0000, 32'h0010_0000, 0, 32'h7fff_ffff, 32'h8000_0000);
        add_particle(0, 32'h0000_0100, 0, 1, 0);
        add_particle(0, 32'h000f_0000, 0, 1, 1);
        drain();
        write_reg(REG_WALL_STYLE, 32'(STYLE_Z));
        add_particle(0, 0, 32'h0000_0001, 1, 0);
        add_particle(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 1, 1);
        drain();

        // Crossed planes.
        set_walls(STYLE_X, 32'h0002_0000, 32'hfffe_0000, 0, 32'h0008_0000, 32'h7fff_ffff);
        add_particle(0, 0, 0, 1, 0);
        add_particle(32'h0001_0000, 0, 0, 1, 0);
        drain();

        // Cylinder of radius 2.0: axis, surface, inside, outside, extremes.
        set_walls(STYLE_CYL, 0, 0, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
        add_particle(0, 0, 32'h1234_5678, 1, 0);
        add_particle(32'h0002_0000, 0, 0, 1, 0);
        add_particle(32'h0001_8000, 32'hffff_8000, 0, 1, 0);
        add_particle(32'hfffd_8000, 32'h0000_8000, 0, 1, 0);
        add_particle(32'h8000_0000, 32'h8000_0000, 0, 1, 1);
        drain();
        write_reg(REG_CYLINDER_RADIUS, 32'h7fff_ffff);
        add_particle(32'h8000_0000, 32'h8000_0000, 0, 1, 1);
        drain();

        // Random phases under each backpressure profile.
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 80;
                recv_idle_pct = 23;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int k = 0; k < 4; k++) random_phase(34);
        end

        $display("Covered %0d force transactions, %0d with repulsion applied,", force_count,
                 applied_count);
        $display("across all wall styles, extreme registers and three backpressure profiles.");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
